// ===== rtl/psa_pkg.sv =====
package psa_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 17;
  localparam int SUM_W      = 33;
  localparam int SQSUM_W    = 47;
  localparam int MAG_W      = 32;
  localparam int PROD_W     = 64;
  localparam int ROOT_W     = 40;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = PROD_W + FRAC_W;
  localparam int DEV_W      = 24;
  localparam int STEP_W     = 6;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(65536);

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic load;
    logic clear;
  } accum_ctrl_t;

endpackage

// ===== rtl/psa_if.sv =====
interface psa_in_if;
  import psa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface psa_out_if;
  import psa_pkg::*;

  logic             valid;
  logic             ready;
  logic [DEV_W-1:0] deviation;
  logic             overflow;

  modport source (output valid, output deviation, output overflow, input ready);
  modport sink (input valid, input deviation, input overflow, output ready);
endinterface

// ===== rtl/population_stdev_accumulator_core.sv =====
// Population standard deviation over sets of signed 16-bit samples. Each
// sample request is taken when samples.valid and samples.ready are both high;
// a sample without last is captured, then accumulated into count, sum and sum
// of squares. The sample marked last closes the set: the block then works
// out floor(256 * sqrt(n*S2 - S1^2) / n) on one shared 64-bit add/subtract
// unit, stepping a small sequencer through a 17-step shift-add product n*S2,
// a 32-step product S1^2, one subtract, a 40-step restoring square root and
// a 40-step restoring divide by n. A set of fewer than two samples, or one
// whose radicand is not positive, reports zero; samples.ready stays low
// until the result request has been taken on results. Sets beyond 65536
// samples keep the figures of the first 65536 and report overflow.
module population_stdev_accumulator_core (
  input logic     clk,
  input logic     rst,
  psa_in_if.sink  samples,
  psa_out_if.source results
);
  import psa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_START,
    S_MULA,
    S_MULB,
    S_DIFF,
    S_SQRT,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic [STEP_W-1:0]          step;
  logic [PROD_W-1:0]          acc;
  logic [PROD_W-1:0]          prod_a;
  logic [MAG_W-1:0]           mag;
  logic [ROOT_W-1:0]          root;
  logic [RAD_W-1:0]           rad;
  logic [DEV_W-1:0]           deviation;
  logic                       overflow;
  logic                       out_valid;

  accum_ctrl_t          accum_ctrl;
  logic [COUNT_W-1:0]   count;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_neg;
  logic [SQSUM_W-1:0]   sqsum;
  logic                 overflowed;

  alu_op_t           alu_op;
  logic [PROD_W-1:0] alu_a;
  logic [PROD_W-1:0] alu_b;
  logic [PROD_W-1:0] alu_res;
  logic              alu_ge;

  psa_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (accum_ctrl),
    .sample     (sample),
    .count      (count),
    .sum        (sum),
    .sqsum      (sqsum),
    .overflowed (overflowed)
  );

  psa_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign sum_neg = ~sum + 1'b1;

  // Accumulate in S_ACC; clear the set once its result request is taken.
  assign accum_ctrl.load  = (state == S_ACC);
  assign accum_ctrl.clear = (state == S_OUT) && results.ready;

  assign samples.ready     = (state == S_IDLE);
  assign results.valid     = out_valid;
  assign results.deviation = deviation;
  assign results.overflow  = overflow;

  // Operand selection for the shared unit, one use per sequencer state.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_MULA: begin
        // MSB-first shift-add: acc = 2*acc + bit(n) * S2
        alu_a = {acc[PROD_W-2:0], 1'b0};
        alu_b = count[step[4:0]] ? PROD_W'(sqsum) : '0;
      end
      S_MULB: begin
        alu_a = {acc[PROD_W-2:0], 1'b0};
        alu_b = mag[step[4:0]] ? PROD_W'(mag) : '0;
      end
      S_DIFF: begin
        alu_op = ALU_SUB;
        alu_a  = prod_a;
        alu_b  = acc;
      end
      S_SQRT: begin
        // bring down the next bit pair, try subtracting 4*root + 1
        alu_op = ALU_SUB;
        alu_a  = {acc[PROD_W-3:0], rad[RAD_W-1 -: 2]};
        alu_b  = PROD_W'({root, 2'b01});
      end
      S_DIV: begin
        // bring down the next dividend bit, try subtracting n
        alu_op = ALU_SUB;
        alu_a  = {acc[PROD_W-2:0], root[ROOT_W-1]};
        alu_b  = PROD_W'(count);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            sample <= samples.sample;
            last   <= samples.last;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          state <= last ? S_START : S_IDLE;
        end
        S_START: begin
          mag      <= sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];
          overflow <= overflowed;
          acc      <= '0;
          step     <= STEP_W'(COUNT_W - 1);
          if (count[COUNT_W-1:1] == '0) begin
            // fewer than two samples: report zero
            deviation <= '0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_MULA;
          end
        end
        S_MULA: begin
          if (step == '0) begin
            prod_a <= alu_res;
            acc    <= '0;
            step   <= STEP_W'(MAG_W - 1);
            state  <= S_MULB;
          end else begin
            acc  <= alu_res;
            step <= step - 1'b1;
          end
        end
        S_MULB: begin
          acc <= alu_res;
          if (step == '0) begin
            state <= S_DIFF;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DIFF: begin
          if (alu_ge && (alu_res != '0)) begin
            rad   <= {alu_res, FRAC_W'(0)};
            acc   <= '0;
            root  <= '0;
            step  <= STEP_W'(ROOT_W - 1);
            state <= S_SQRT;
          end else begin
            // non-positive radicand: report zero
            deviation <= '0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_SQRT: begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          root <= {root[ROOT_W-2:0], alu_ge};
          if (step == '0) begin
            // the divide must start from a zero remainder
            acc   <= '0;
            step  <= STEP_W'(ROOT_W - 1);
            state <= S_DIV;
          end else begin
            acc  <= alu_ge ? alu_res : alu_a;
            step <= step - 1'b1;
          end
        end
        S_DIV: begin
          // root register doubles as dividend and quotient; the remainder in acc
          // starts from zero, cleared when the square root finished
          if (alu_ge) begin
            acc  <= alu_res;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            acc  <= alu_a;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          if (step == '0) begin
            deviation <= alu_ge ? {root[DEV_W-2:0], 1'b1} : {root[DEV_W-2:0], 1'b0};
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_OUT: begin
          // hold the result until the request is taken
          if (results.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/psa_alu.sv =====
module psa_alu (
  input  psa_pkg::alu_op_t          op,
  input  logic [psa_pkg::PROD_W-1:0] a,
  input  logic [psa_pkg::PROD_W-1:0] b,
  output logic [psa_pkg::PROD_W-1:0] res,
  output logic                       ge
);
  import psa_pkg::*;

  logic [PROD_W:0] wide;

  always_comb begin
    case (op)
      ALU_ADD: wide = {1'b0, a} + {1'b0, b};
      ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      default: wide = '0;
    endcase
  end

  assign res = wide[PROD_W-1:0];
  // no borrow out of the subtract means a >= b
  assign ge  = ~wide[PROD_W];

endmodule

// ===== rtl/psa_accum.sv =====
module psa_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  psa_pkg::accum_ctrl_t               ctrl,
  input  logic signed [psa_pkg::SAMPLE_W-1:0] sample,
  output logic [psa_pkg::COUNT_W-1:0]         count,
  output logic [psa_pkg::SUM_W-1:0]           sum,
  output logic [psa_pkg::SQSUM_W-1:0]         sqsum,
  output logic                                overflowed
);
  import psa_pkg::*;

  logic signed [2*SAMPLE_W-1:0] square;

  assign square = sample * sample;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count      <= '0;
      sum        <= '0;
      sqsum      <= '0;
      overflowed <= 1'b0;
    end else if (ctrl.load) begin
      if (count == MAX_COUNT) begin
        // count full: drop the sample, flag it
        overflowed <= 1'b1;
      end else begin
        count <= count + 1'b1;
        sum   <= sum + SUM_W'(sample);
        sqsum <= sqsum + SQSUM_W'($unsigned(square));
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import psa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 200;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  typedef struct {
    logic [DEV_W-1:0] deviation;
    logic             overflow;
  } dev_result_t;

  // Keeps its own copy of the set accumulators and the queue of deviations
  // still owed by the block.
  class stdev_board;
    logic [COUNT_W-1:0]       n_seen;
    logic signed [SUM_W-1:0]  total;
    logic [SQSUM_W-1:0]       sq_total;
    logic                     clipped;
    dev_result_t              owed[$];
    int unsigned              failures;
    int unsigned              sets_closed;
    int unsigned              samples_taken;

    function new();
      clear();
      failures      = 0;
      sets_closed   = 0;
      samples_taken = 0;
    endfunction

    function void clear();
      n_seen   = '0;
      total    = '0;
      sq_total = '0;
      clipped  = 1'b0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // floor(sqrt(r * 2^FRAC_W)), restoring, two radicand bits per step
    function logic [ROOT_W-1:0] scaled_root(logic [63:0] r);
      logic [RAD_W-1:0]  x;
      logic [ROOT_W-1:0] q;
      logic [63:0]       rem;
      logic [63:0]       trial;
      x   = RAD_W'(r) << FRAC_W;
      q   = '0;
      rem = '0;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
        rem   = (rem << 2) | 64'(x[2*i +: 2]);
        trial = 64'({q, 2'b01});
        if (rem >= trial) begin
          rem = rem - trial;
          q   = {q[ROOT_W-2:0], 1'b1};
        end else begin
          q   = {q[ROOT_W-2:0], 1'b0};
        end
      end
      return q;
    endfunction

    function logic [DEV_W-1:0] deviation();
      longint           signed_sum;
      logic [63:0]      mag;
      logic [63:0]      a;
      logic [63:0]      b;
      logic [63:0]      n64;
      logic [63:0]      quotient;
      if (n_seen < 2) return '0;
      signed_sum = total;
      mag        = (signed_sum < 0) ? 64'(-signed_sum) : 64'(signed_sum);
      n64        = 64'(n_seen);
      a          = n64 * 64'(sq_total);
      b          = mag * mag;
      if (a <= b) return '0;
      quotient = 64'(scaled_root(a - b)) / n64;
      return quotient[DEV_W-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic closes);
      logic signed [31:0] sq;
      dev_result_t        e;
      samples_taken++;
      if (n_seen >= MAX_COUNT) begin
        clipped = 1'b1;
      end else begin
        sq       = s * s;
        n_seen   = n_seen + 1'b1;
        total    = total + s;
        sq_total = sq_total + SQSUM_W'($unsigned(sq));
      end
      if (closes) begin
        e.deviation = deviation();
        e.overflow  = clipped;
        owed.push_back(e);
        sets_closed++;
        clear();
      end
    endfunction

    function void check_result(logic [DEV_W-1:0] dev, logic ovf);
      dev_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: result with none owed: deviation %0d overflow %0d", $time, dev, ovf);
        failures++;
        return;
      end
      e = owed.pop_front();
      if (dev !== e.deviation) begin
        $display("%0t: deviation expected %0d, actual %0d", $time, e.deviation, dev);
        failures++;
      end
      if (ovf !== e.overflow) begin
        $display("%0t: overflow expected %0d, actual %0d", $time, e.overflow, ovf);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Idling switches for each side; both stay clear in the closing stretch.
  logic src_idle  = 1'b0;
  logic sink_idle = 1'b0;

  int unsigned quiet_cycles;

  stdev_board board;

  psa_in_if  samples ();
  psa_out_if results ();

  population_stdev_accumulator_core dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch both channels at the rising edge: feed accepted sample requests to
  // the predictor, hold each result request against the oldest deviation
  // owed, and drop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (samples.valid && samples.ready) begin
        board.note_sample(samples.sample, samples.last);
      end
      if (results.valid && results.ready) begin
        board.check_result(results.deviation, results.overflow);
      end
      if ((samples.valid && samples.ready) || (results.valid && results.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: while idling is on, drop ready in bursts at random.
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle && $urandom_range(0, 3) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // Present one sample request after an optional gap and hold it until the
  // block takes it.
  task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic closes, int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      samples.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    samples.valid  <= 1'b1;
    samples.sample <= s;
    samples.last   <= closes;
    do @(posedge clk); while (!samples.ready);
  endtask

  // Lower valid and hold off until every owed deviation has come back.
  task automatic drain();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap();
    if (src_idle && $urandom_range(0, 3) == 0) return $urandom_range(1, 14);
    return 0;
  endfunction

  // Lean on the extremes and on small values; the rest spans all 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
      3:       return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 3));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Random sets, mostly short so results come often; now and then a longer
  // one. Every so often re-pick which sides idle, and optionally hold off
  // once until the block has caught up.
  task automatic run_sets(int unsigned target, logic with_idling, logic pause_midway);
    int unsigned done;
    int unsigned len;
    logic        paused;
    done   = 0;
    paused = 1'b0;
    while (done < target) begin
      if (with_idling && $urandom_range(0, 15) == 0) begin
        src_idle  = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = 2;
        2:       len = $urandom_range(20, 60);
        default: len = $urandom_range(3, 10);
      endcase
      for (int i = 0; i < len; i++) begin
        send_item(pick_sample(), i == len - 1, pick_gap());
      end
      done += len;
      if (pause_midway && !paused && done >= target / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    board = new();
    samples.valid  = 1'b0;
    samples.sample = '0;
    samples.last   = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets: single samples at both extremes, a set whose radicand
    // is exactly zero, the widest possible spread, and bit patterns that
    // toggle every sample bit.
    send_item(SAMPLE_MAX, 1'b1, 0);
    send_item(SAMPLE_MIN, 1'b1, 0);
    send_item(16'sh0000, 1'b0, 0);
    send_item(16'sh0000, 1'b1, 0);
    send_item(SAMPLE_MIN, 1'b0, 0);
    send_item(SAMPLE_MIN, 1'b1, 0);
    send_item(SAMPLE_MIN, 1'b0, 0);
    send_item(SAMPLE_MAX, 1'b1, 0);
    send_item(SAMPLE_MAX, 1'b0, 0);
    send_item(SAMPLE_MIN, 1'b0, 0);
    send_item(16'sh0000, 1'b1, 0);
    send_item(16'sh0001, 1'b0, 0);
    send_item(16'sh5555, 1'b0, 0);
    send_item(16'shAAAA, 1'b0, 0);
    send_item(16'sh0000, 1'b1, 0);
    send_item(16'shFFFF, 1'b0, 0);
    send_item(16'sh0001, 1'b1, 0);

    // Main random stretch with idling on both sides and one hold-off.
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    run_sets(1000, 1'b1, 1'b1);

    // Closing stretch at full rate, no idling either side.
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_sets(300, 1'b0, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d sample requests in %0d sets of mixed length,",
             board.samples_taken, board.sets_closed);
    $display("with random idling on both channels and a full drain part way through.");
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== population_stdev_accumulator_core.f =====
rtl/psa_pkg.sv
rtl/psa_if.sv
rtl/psa_alu.sv
rtl/psa_accum.sv
rtl/population_stdev_accumulator_core.sv
tb/tb.sv
